[rtl/pdfo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase-difference frequency offset package
// Shared widths, pipeline depths, the arctangent table and the scale constants.
// ----------------------------------------------------------------------------
package pdfo_pkg;

    localparam int ANGLE_ITERS = 28;
    localparam int PRE_SHIFT   = 20;
    localparam int XY_W        = 30;
    localparam int ANGLE_W     = 32;
    localparam int MAG_W       = 32;
    localparam int PROD_W      = 64;
    localparam int HZ_SHIFT    = 44;
    localparam int HZ_W        = 21;
    localparam int RND_W       = HZ_W - 1;

    localparam int LANE_DEPTH  = ANGLE_ITERS + 2;
    localparam int SCALE_DEPTH = 3;
    localparam int PIPE_DEPTH  = LANE_DEPTH + SCALE_DEPTH;

    typedef logic signed [XY_W-1:0]    xy_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic undef;
        logic i_zero;
        logic q_zero;
        logic q_neg;
        logic neg;
    } side_t;

    localparam angle_t HALF_PI_Q30 = 32'sd1686629713;

    localparam logic [MAG_W-1:0]  HZ_MUL     = 32'd2963175705;
    localparam logic [PROD_W-1:0] ROUND_BIAS = 64'h0000_0800_0000_0000;

    localparam angle_t ATAN_Q30 [ANGLE_ITERS] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8
    };

endpackage

[rtl/pdfo_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined arctangent lane
// Forms atan(q/i) in Q30 radians with one vectoring step per register stage.
// ----------------------------------------------------------------------------
module pdfo_cordic (
    input  logic                clk,
    input  logic                en,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          q_byte,
    output pdfo_pkg::angle_t    angle,
    output logic                undef
);

    pdfo_pkg::xy_t    x_reg    [pdfo_pkg::ANGLE_ITERS+1];
    pdfo_pkg::xy_t    y_reg    [pdfo_pkg::ANGLE_ITERS+1];
    pdfo_pkg::angle_t z_reg    [pdfo_pkg::ANGLE_ITERS+1];
    pdfo_pkg::side_t  side_reg [pdfo_pkg::ANGLE_ITERS+1];

    pdfo_pkg::angle_t angle_reg;
    logic             undef_reg;

    logic [8:0]       i_mag;
    logic [8:0]       q_mag;
    pdfo_pkg::side_t  side_next;
    pdfo_pkg::side_t  side_last;
    pdfo_pkg::angle_t z_last;
    pdfo_pkg::angle_t angle_next;

    always_comb
    begin
        i_mag = i_byte[7] ? (9'd0 - {1'b1, i_byte}) : {1'b0, i_byte};
        q_mag = q_byte[7] ? (9'd0 - {1'b1, q_byte}) : {1'b0, q_byte};
        side_next.i_zero = (i_byte == 8'd0);
        side_next.q_zero = (q_byte == 8'd0);
        side_next.undef  = side_next.i_zero && side_next.q_zero;
        side_next.q_neg  = q_byte[7];
        side_next.neg    = i_byte[7] ^ q_byte[7];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= {1'b0, i_mag, {pdfo_pkg::PRE_SHIFT{1'b0}}};
            y_reg[0]    <= {1'b0, q_mag, {pdfo_pkg::PRE_SHIFT{1'b0}}};
            z_reg[0]    <= '0;
            side_reg[0] <= side_next;
        end
    end

    for (genvar k = 0; k < pdfo_pkg::ANGLE_ITERS; k++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[k][pdfo_pkg::XY_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + pdfo_pkg::ATAN_Q30[k];
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - pdfo_pkg::ATAN_Q30[k];
                end
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // The last x and y values are not needed; only the angle and the undefined flag leave the lane.
    always_comb
    begin
        side_last = side_reg[pdfo_pkg::ANGLE_ITERS];
        z_last    = z_reg[pdfo_pkg::ANGLE_ITERS];
        priority if (side_last.i_zero)
        begin
            angle_next = side_last.q_neg ? -pdfo_pkg::HALF_PI_Q30 : pdfo_pkg::HALF_PI_Q30;
        end
        else if (side_last.q_zero)
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = side_last.neg ? -z_last : z_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
            undef_reg <= side_last.undef;
        end
    end

    assign angle = angle_reg;
    assign undef = undef_reg;

endmodule

[rtl/pdfo_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Angle difference scaler
// Subtracts two angles, scales by the Hz factor and rounds half away from zero.
// ----------------------------------------------------------------------------
module pdfo_scale (
    input  logic                        clk,
    input  logic                        en,
    input  pdfo_pkg::angle_t            angle_cur,
    input  pdfo_pkg::angle_t            angle_prev,
    input  logic                        undef_cur,
    input  logic                        undef_prev,
    output logic signed [pdfo_pkg::HZ_W-1:0] hz,
    output logic                        undef
);

    logic signed [pdfo_pkg::ANGLE_W:0] diff;
    logic [pdfo_pkg::ANGLE_W:0]        diff_abs;

    logic [pdfo_pkg::MAG_W-1:0]  mag_reg;
    logic                        sign_a_reg;
    logic                        undef_a_reg;

    logic [pdfo_pkg::PROD_W-1:0] prod_reg;
    logic                        sign_b_reg;
    logic                        undef_b_reg;

    logic [pdfo_pkg::PROD_W-1:0] round_sum;
    logic [pdfo_pkg::RND_W-1:0]  rounded;
    logic signed [pdfo_pkg::HZ_W-1:0] hz_next;

    logic signed [pdfo_pkg::HZ_W-1:0] hz_reg;
    logic                        undef_reg;

    always_comb
    begin
        diff     = {angle_cur[pdfo_pkg::ANGLE_W-1], angle_cur}
                 - {angle_prev[pdfo_pkg::ANGLE_W-1], angle_prev};
        diff_abs = diff[pdfo_pkg::ANGLE_W] ? -diff : diff;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= diff_abs[pdfo_pkg::MAG_W-1:0];
            sign_a_reg  <= diff[pdfo_pkg::ANGLE_W];
            undef_a_reg <= undef_cur || undef_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= {{(pdfo_pkg::PROD_W-pdfo_pkg::MAG_W){1'b0}}, mag_reg}
                         * {{(pdfo_pkg::PROD_W-pdfo_pkg::MAG_W){1'b0}}, pdfo_pkg::HZ_MUL};
            sign_b_reg  <= sign_a_reg;
            undef_b_reg <= undef_a_reg;
        end
    end

    always_comb
    begin
        round_sum = prod_reg + pdfo_pkg::ROUND_BIAS;
        rounded   = round_sum[pdfo_pkg::HZ_SHIFT +: pdfo_pkg::RND_W];
        if (undef_b_reg)
        begin
            hz_next = '0;
        end
        else if (sign_b_reg)
        begin
            hz_next = -$signed({1'b0, rounded});
        end
        else
        begin
            hz_next = $signed({1'b0, rounded});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hz_reg    <= hz_next;
            undef_reg <= undef_b_reg;
        end
    end

    assign hz    = hz_reg;
    assign undef = undef_reg;

endmodule

[rtl/phase_difference_freq_offset.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase-difference frequency offset estimator
// Two pipelined arctangent lanes feed a subtract, scale and round pipeline.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[31:0] = packed_samples
//  m_axis    out        tdata[20:0] = freq_offset_hz, tuser[0] = undefined_result
//
//  One request is accepted per clock while the output is not stalled; each result
//  passes through the 28 arctangent steps plus five other register stages.
//  Reset clears only the valid bits of the pipeline.
//  The whole pipeline holds while a result waits at the output and
//  m_axis_tready is low; then s_axis_tready is low as well.
// ----------------------------------------------------------------------------
module phase_difference_freq_offset (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] packed_samples
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] freq_offset_hz, [23:21] zero
    output logic        m_axis_tuser    // [0] undefined_result
);

    logic [pdfo_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic                            en;

    pdfo_pkg::angle_t angle_cur;
    pdfo_pkg::angle_t angle_prev;
    logic             undef_cur;
    logic             undef_prev;

    logic signed [pdfo_pkg::HZ_W-1:0] hz;
    logic                             undef;

    assign en = !valid_reg[pdfo_pkg::PIPE_DEPTH-1] || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[pdfo_pkg::PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    pdfo_cordic u_cordic_cur (
        .clk    (clk),
        .en     (en),
        .i_byte (s_axis_tdata[31:24]),
        .q_byte (s_axis_tdata[23:16]),
        .angle  (angle_cur),
        .undef  (undef_cur)
    );

    pdfo_cordic u_cordic_prev (
        .clk    (clk),
        .en     (en),
        .i_byte (s_axis_tdata[15:8]),
        .q_byte (s_axis_tdata[7:0]),
        .angle  (angle_prev),
        .undef  (undef_prev)
    );

    pdfo_scale u_scale (
        .clk        (clk),
        .en         (en),
        .angle_cur  (angle_cur),
        .angle_prev (angle_prev),
        .undef_cur  (undef_cur),
        .undef_prev (undef_prev),
        .hz         (hz),
        .undef      (undef)
    );

    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[pdfo_pkg::PIPE_DEPTH-1];
    assign m_axis_tdata  = {3'b000, hz};
    assign m_axis_tuser  = undef;

endmodule
